// ----- rtl/core/vcp_pkg.sv -----
// Shared constants and types for the voxel projection lookup core.
package vcp_pkg;
  localparam int FEAT_H  = 64;
  localparam int FEAT_W  = 176;
  localparam int CAMERAS = 6;
  localparam int GRID_Y  = 200;
  localparam int GRID_Z  = 4;
  localparam int SLOTS   = CAMERAS * 12;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ROW_W   = 17;
  localparam int VOX_W   = 18;
  localparam int MAP_W   = 18;
  localparam int COEF_W  = 32;
  // dot product width: 32b coef x 11b coord, 4 terms
  localparam int ACC_W   = 46;
  localparam int CAM_W   = $clog2(CAMERAS + 1);
  localparam logic [ROW_W-1:0] NO_ROW = ROW_W'(CAMERAS * FEAT_H * FEAT_W);
  localparam logic [MAP_W-1:0] MAP_RESET = MAP_W'(181896);

  // voxel / PLANE by reciprocal multiply, exact over the whole 18-bit index range
  localparam int PLANE    = GRID_Y * GRID_Z;
  localparam int RECIP_SH = 28;
  localparam int RECIP_W  = 19;
  localparam logic [RECIP_W-1:0] PLANE_RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(PLANE) - 64'd1) / 64'(PLANE));

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  // divider request / response
  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] num;
    logic [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] quo;
  } div_rsp_t;
endpackage

// ----- rtl/core/vcp_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module vcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/vcp_div.sv -----
// Restoring divider, one quotient bit per cycle, rounds half to even.
module vcp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vcp_pkg::div_req_t req,
  output vcp_pkg::div_rsp_t rsp
);
  import vcp_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] den_r, den_nxt;
  logic [ACC_W-1:0] q_r, q_nxt;
  logic [ACC_W:0]   rem_r, rem_nxt;
  logic [ACC_W-1:0] quo_r, quo_nxt;
  logic [ACC_W:0]   trial;
  logic [ACC_W+1:0] twice;
  logic             up;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] qa;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = '0;
    twice    = '0;
    up       = 1'b0;
    mag      = '0;
    qa       = '0;
    if (req.start) begin
      neg_nxt  = req.num[ACC_W-1];
      q_nxt    = req.num[ACC_W-1] ? (~req.num + 1'b1) : req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(ACC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        trial = {rem_r[ACC_W-1:0], q_r[ACC_W-1]};
        q_nxt = {q_r[ACC_W-2:0], 1'b0};
        if (trial >= {1'b0, den_r}) begin
          rem_nxt  = trial - {1'b0, den_r};
          q_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial;
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        // magnitude quotient q_r, remainder rem_r; fix sign then round
        twice = {rem_r, 1'b0};
        if (!neg_r) begin
          up  = (twice > {2'b0, den_r}) || (twice == {2'b0, den_r} && q_r[0]);
          quo_nxt = q_r + ACC_W'(up);
        end else if (rem_r == '0) begin
          quo_nxt = ~q_r + 1'b1;
        end else begin
          // floor = -(q+1), r' = den - rem
          mag = den_r - rem_r[ACC_W-1:0];
          qa  = ~(q_r + 1'b1) + 1'b1;
          twice = {1'b0, mag, 1'b0};
          up  = (twice > {2'b0, den_r}) || (twice == {2'b0, den_r} && qa[0]);
          quo_nxt = qa + ACC_W'(up);
        end
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
endmodule

// ----- rtl/core/voxel_camera_projection_lut_core.sv -----
// Top level: coefficient store, shared MAC and divider under a sequencer.
//
// Input channel in_*: in_command 0 loads coef_value into slot coef_index (slots past
// the store are dropped); in_command 1 projects voxel_index through all cameras.
// Output channel out_*: one request per projection, carrying voxel_echo, table_row
// and seen. Loads give no result.
// cfg_we writes the 18-bit camera block map; write only while idle.
// Loads can follow back to back. A projection splits the grid coordinates, then per
// camera reads the coefficients through the store into one 32x11 multiplier and
// 46-bit accumulator, runs two serial divisions on the one shared divider and
// checks the result; the divisions are skipped when the depth is not positive.
// The divisions set the rate, and no new request is taken until the projection is
// through and its result accepted.
// Reset clears control state and sets the block map so camera c uses block c; the
// coefficient store is not cleared and must be loaded before projecting.
// When the receiver stalls, the result waits in the output register and no new
// request is taken until it is accepted; the next one can go the cycle after.
module voxel_camera_projection_lut_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [6:0]                   in_coef_index,
  input  logic signed [31:0]           in_coef_value,
  input  logic [17:0]                  in_voxel_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [17:0]                  out_voxel_echo,
  output logic [16:0]                  out_table_row,
  output logic                         out_seen,
  input  logic                         cfg_we,
  input  logic [vcp_pkg::MAP_W-1:0]    cfg_wdata
);
  import vcp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_RD, S_MAC, S_DIVU, S_WU, S_DIVW, S_WW, S_CHECK, S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MAP_W-1:0]        map_r;
  logic [VOX_W-1:0]        vox_r, vox_nxt;
  logic [10:0]             xi_r, xi_nxt;
  logic signed [10:0]      cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [CAM_W-1:0]        cam_r, cam_nxt;
  logic [3:0]              el_r, el_nxt;
  logic                    rdv_r, rdv_nxt;
  logic [3:0]              macel_r, macel_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] u_r, u_nxt, w_r, w_nxt, d_r, d_nxt;
  logic signed [ACC_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic                    seen_r, seen_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic signed [10:0]      coord;
  logic signed [ACC_W-1:0] prod;
  logic [SLOT_W-1:0]       raddr;
  logic [COEF_W-1:0]       rdata;
  logic                    ram_we;
  div_req_t                dreq;
  div_rsp_t                drsp;
  logic [2:0]              blk;
  logic [2*MAP_W-1:0]      map_ext;
  logic                    acc_in;
  logic [VOX_W+RECIP_W-1:0] xprod;
  logic [9:0]              prem;

  assign ram_we = in_valid && in_ready && in_command == CMD_LOAD &&
                  in_coef_index < 7'(SLOTS);
  assign raddr  = SLOT_W'(cam_r * 12 + CAM_W'(0)) + SLOT_W'(el_r);

  vcp_ram #(.WIDTH(COEF_W), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_coef_index[SLOT_W-1:0]),
    .wdata (in_coef_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  vcp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign acc_in   = in_valid && in_ready;

  // grid split: xi by reciprocal multiply, then the remainder within the plane
  assign xprod = {{RECIP_W{1'b0}}, in_voxel_index} * {{VOX_W{1'b0}}, PLANE_RECIP};
  assign prem  = 10'(vox_r - VOX_W'(xi_r * PLANE));

  always_comb begin
    case (macel_r[1:0])
      2'd0:    coord = cx_r;
      2'd1:    coord = cy_r;
      2'd2:    coord = cz_r;
      default: coord = 11'sd2;
    endcase
    prod = ACC_W'($signed(rdata) * coord);
  end

  assign map_ext = {{MAP_W{1'b0}}, map_r} >> (3 * cam_r);
  assign blk     = map_ext[2:0];

  always_comb begin
    state_nxt  = state_r;
    vox_nxt    = vox_r;
    xi_nxt     = xi_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    cam_nxt    = cam_r;
    el_nxt     = el_r;
    rdv_nxt    = 1'b0;
    macel_nxt  = macel_r;
    acc_nxt    = acc_r;
    u_nxt      = u_r;
    w_nxt      = w_r;
    d_nxt      = d_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    row_nxt    = row_r;
    seen_nxt   = seen_r;
    ovalid_nxt = ovalid_r && !out_ready;
    dreq       = '0;
    case (state_r)
      S_IDLE: begin
        if (acc_in && in_command == CMD_PROJECT) begin
          vox_nxt   = in_voxel_index;
          xi_nxt    = 11'(xprod >> RECIP_SH);
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cx_nxt    = $signed(xi_r) - 11'sd100;
        cy_nxt    = $signed(11'(prem / GRID_Z)) - 11'sd100;
        cz_nxt    = $signed(11'(prem % GRID_Z) * 11'd3) - 11'sd8;
        cam_nxt   = '0;
        el_nxt    = '0;
        row_nxt   = NO_ROW;
        seen_nxt  = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: begin
        el_nxt    = el_r + 1'b1;
        rdv_nxt   = 1'b1;
        macel_nxt = el_r;
        acc_nxt   = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        if (rdv_r) begin
          acc_nxt = ((macel_r[1:0] == 2'd0) ? '0 : acc_r) + prod;
          if (macel_r[1:0] == 2'd3) begin
            case (macel_r[3:2])
              2'd0:    u_nxt = acc_r + prod;
              2'd1:    w_nxt = acc_r + prod;
              default: d_nxt = acc_r + prod;
            endcase
          end
        end
        if (el_r != 4'd12) begin
          el_nxt    = el_r + 1'b1;
          rdv_nxt   = 1'b1;
          macel_nxt = el_r;
        end else if (rdv_r) begin
          rdv_nxt   = 1'b0;
          macel_nxt = macel_r;
        end else if (d_r > 0) begin
          dreq.start = 1'b1;
          dreq.num   = u_r;
          dreq.den   = d_r;
          state_nxt  = S_WU;
        end else begin
          state_nxt = S_CHECK;
          px_nxt    = '1;
        end
      end
      S_WU: begin
        if (drsp.done) begin
          px_nxt     = drsp.quo;
          dreq.start = 1'b1;
          dreq.num   = w_r;
          dreq.den   = d_r;
          state_nxt  = S_WW;
        end
      end
      S_WW: begin
        if (drsp.done) begin
          py_nxt    = drsp.quo;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (px_r >= 0 && py_r >= 0 && px_r < FEAT_W && py_r < FEAT_H) begin
          row_nxt  = ROW_W'(blk * (FEAT_H * FEAT_W)) + ROW_W'(py_r[9:0] * FEAT_W)
                   + ROW_W'(px_r[9:0]);
          seen_nxt = 1'b1;
        end
        if (cam_r == CAM_W'(CAMERAS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          cam_nxt   = cam_r + 1'b1;
          el_nxt    = '0;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      map_r    <= MAP_RESET;
      ovalid_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rdv_r    <= rdv_nxt;
      if (cfg_we) begin
        map_r <= cfg_wdata;
      end
    end
    vox_r   <= vox_nxt;
    xi_r    <= xi_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    cz_r    <= cz_nxt;
    cam_r   <= cam_nxt;
    el_r    <= el_nxt;
    macel_r <= macel_nxt;
    acc_r   <= acc_nxt;
    u_r     <= u_nxt;
    w_r     <= w_nxt;
    d_r     <= d_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    row_r   <= row_nxt;
    seen_r  <= seen_nxt;
  end

  assign out_valid      = ovalid_r;
  assign out_voxel_echo = vox_r;
  assign out_table_row  = row_r;
  assign out_seen       = seen_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready while busy");
  a_seen_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_seen) |-> out_table_row == NO_ROW) else $error("unseen row wrong");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT) else $error("stray result");
endmodule

// ----- sim/tb_voxel_camera_projection_lut_core.sv -----
// Self-checking testbench for the voxel projection lookup core.
`timescale 1ns / 1ps

module tb_voxel_camera_projection_lut_core;
  import vcp_pkg::*;

  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic        command;
    logic [6:0]  coef_index;
    logic [31:0] coef_value;
    logic [17:0] voxel_index;
  } vox_req_t;

  typedef struct packed {
    logic [17:0] voxel_echo;
    logic [16:0] table_row;
    logic        seen;
  } lut_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [6:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic [17:0] in_voxel_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [17:0] out_voxel_echo;
  logic [16:0] out_table_row;
  logic out_seen;
  logic cfg_we = 1'b0;
  logic [MAP_W-1:0] cfg_wdata = '0;

  vox_req_t   pending_reqs[$];
  lut_entry_t expected_rows[$];
  logic signed [31:0] coef_mirror[SLOTS];
  logic [MAP_W-1:0] block_map;
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int got = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_off = 0;
  bit driving = 1'b0;

  voxel_camera_projection_lut_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .in_voxel_index(in_voxel_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_voxel_echo(out_voxel_echo),
    .out_table_row(out_table_row), .out_seen(out_seen),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint round_even_div(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    if (r < 0) begin
      q -= 1;
      r += den;
    end
    if (2 * r > den || (2 * r == den && q[0])) q += 1;
    return q;
  endfunction

  function automatic longint cam_dot(int base, longint x, longint y, longint z);
    return longint'(coef_mirror[base]) * x + longint'(coef_mirror[base + 1]) * y +
           longint'(coef_mirror[base + 2]) * z + 2 * longint'(coef_mirror[base + 3]);
  endfunction

  // updates the mirror store; returns 1 with the entry for a projection
  function automatic bit predict_entry(vox_req_t r, output lut_entry_t e);
    longint xi, yi, zi, u, w, d, px, py, row;
    bit hit;
    if (r.command == CMD_LOAD) begin
      if (r.coef_index < SLOTS) coef_mirror[r.coef_index] = r.coef_value;
      return 1'b0;
    end
    xi = r.voxel_index / (GRID_Y * GRID_Z);
    yi = (r.voxel_index / GRID_Z) % GRID_Y;
    zi = r.voxel_index % GRID_Z;
    row = CAMERAS * FEAT_H * FEAT_W;
    hit = 1'b0;
    for (int c = 0; c < CAMERAS; c++) begin
      u = cam_dot(c * 12, xi - 100, yi - 100, 3 * zi - 8);
      w = cam_dot(c * 12 + 4, xi - 100, yi - 100, 3 * zi - 8);
      d = cam_dot(c * 12 + 8, xi - 100, yi - 100, 3 * zi - 8);
      if (d > 0) begin
        px = round_even_div(u, d);
        py = round_even_div(w, d);
        if (px >= 0 && py >= 0 && px < FEAT_W && py < FEAT_H) begin
          row = ((block_map >> (3 * c)) & 7) * FEAT_H * FEAT_W + py * FEAT_W + px;
          hit = 1'b1;
        end
      end
    end
    e.voxel_echo = r.voxel_index;
    e.table_row = row[16:0];
    e.seen = hit;
    return 1'b1;
  endfunction

  function automatic void enqueue(vox_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  always @(posedge clk) begin
    lut_entry_t e;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (predict_entry(pending_reqs[0], e))
          expected_rows.insert(expected_rows.size(), e);
        void'(pending_reqs.pop_front());
        sent <= sent + 1;
        in_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (driving && pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_command <= pending_reqs[0].command;
          in_coef_index <= pending_reqs[0].coef_index;
          in_coef_value <= pending_reqs[0].coef_value;
          in_voxel_index <= pending_reqs[0].voxel_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch %s at result %0d: expected %0d got %0d", what, got, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    lut_entry_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got <= got + 1;
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected request", 0, out_voxel_echo);
        end else begin
          e = expected_rows.pop_front();
          if (out_voxel_echo !== e.voxel_echo)
            report_mismatch("voxel_echo", e.voxel_echo, out_voxel_echo);
          if (out_table_row !== e.table_row)
            report_mismatch("table_row", e.table_row, out_table_row);
          if (out_seen !== e.seen) report_mismatch("seen", e.seen, out_seen);
        end
        out_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic vox_req_t load_req(int slot, logic [31:0] val);
    vox_req_t r;
    r = '0;
    r.command = CMD_LOAD;
    r.coef_index = slot[6:0];
    r.coef_value = val;
    r.voxel_index = 18'($urandom());
    return r;
  endfunction

  function automatic vox_req_t project_req(logic [17:0] vox);
    vox_req_t r;
    r.command = CMD_PROJECT;
    r.coef_index = 7'($urandom());
    r.coef_value = $urandom();
    r.voxel_index = vox;
    return r;
  endfunction

  // camera matrix aimed at the grid centre; the focal scale and offsets are jittered
  task automatic queue_camera(int c, bit wild);
    int f;
    logic [31:0] m[12];
    f = $urandom_range(1, 40);
    m[0] = 32'(f * 65536);    m[1] = 32'($urandom_range(0, 131072) - 65536);
    m[2] = 32'($urandom_range(0, 65536) - 32768);
    m[3] = 32'((88 * 64 + $urandom_range(0, 2000) - 1000) * 65536);
    m[4] = 32'($urandom_range(0, 65536) - 32768);  m[5] = 32'(f * 65536 / 2);
    m[6] = 32'($urandom_range(0, 65536) - 32768);
    m[7] = 32'((32 * 64 + $urandom_range(0, 1000) - 500) * 65536);
    m[8] = 32'($urandom_range(0, 2048) - 1024);    m[9] = 32'($urandom_range(0, 2048) - 1024);
    m[10] = 32'($urandom_range(0, 2048) - 1024);
    m[11] = 32'($urandom_range(2, 70) * 65536 / 2);
    for (int k = 0; k < 12; k++) begin
      if (wild && $urandom_range(0, 2) == 0) m[k] = $urandom();
      enqueue(load_req(c * 12 + k, m[k]));
    end
  endtask

  task automatic drain_and_settle();
    while (pending_reqs.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_map(logic [MAP_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    block_map = val;
  endtask

  initial begin
    logic [MAP_W-1:0] maps[5];
    block_map = MAP_RESET;
    for (int k = 0; k < SLOTS; k++) coef_mirror[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    driving = 1'b1;

    // directed: all slots, extreme values, dropped slots, edge voxels
    for (int c = 0; c < CAMERAS; c++) queue_camera(c, 1'b0);
    enqueue(load_req(72, 32'h7fffffff));
    enqueue(load_req(127, 32'h80000000));
    enqueue(project_req(18'd0));
    enqueue(project_req(18'd159999));
    enqueue(project_req(18'd80402));
    enqueue(project_req(18'h3ffff));
    enqueue(project_req(18'd160000));
    enqueue(load_req(11, 32'h80000000));
    enqueue(project_req(18'd80402));
    enqueue(load_req(11, 32'h7fffffff));
    enqueue(project_req(18'd80402));
    drain_and_settle();

    maps[0] = '0; maps[1] = '1; maps[2] = MAP_RESET;
    maps[3] = 18'h2db6d; maps[4] = MAP_W'($urandom());
    for (int ph = 0; ph < 5; ph++) begin
      write_map(maps[ph]);
      for (int k = 0; k < 75; k++) begin
        if ($urandom_range(0, 19) == 0)
          queue_camera($urandom_range(0, CAMERAS - 1), 1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 9) == 0)
          enqueue(load_req($urandom_range(0, 127), $urandom()));
        else if ($urandom_range(0, 9) == 0)
          enqueue(project_req(18'($urandom())));
        else
          enqueue(project_req(18'($urandom_range(0, 159999))));
      end
      if (ph == 2) begin
        repeat (20) @(posedge clk);
        hold_off = 3000;
      end
      drain_and_settle();
    end

    $display("sent %0d requests, checked %0d results over %0d cycles", sent, got, cycles);
    $display("covered all slots, dropped loads, off-grid voxels and five block maps");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
